@@ sv/can_rx_frame_ring_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef CAN_RX_FRAME_RING_TOP_ASSERT_SVH
`define CAN_RX_FRAME_RING_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/crr_pkg.sv @@
`timescale 1ns / 1ps
package crr_pkg;

	localparam int DEF_RING_DEPTH = 16;

	// Configuration register indexes.
	localparam logic CFG_IDX_W = 1'b1;
	localparam logic REG_QUEUE_SIZE = 1'b0;
	localparam logic REG_ENABLED = 1'b1;
	localparam int CFG_DATA_W = 5;
	localparam logic [4:0] QUEUE_SIZE_RST = 5'd16;

	// Input mode codes.
	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam int S_TDATA_W = 104;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 168;
	localparam int M_TUSER_W = 2;

	localparam logic [3:0] MAX_LEN = 4'd8;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_CLEAR
	} op_e_t;

	typedef struct packed {
		logic        ext;
		logic [28:0] id;
		logic [3:0]  len;
		logic [63:0] data;
	} frame_t;

	typedef struct packed {
		op_e_t  op;
		frame_t frame;
	} cmd_t;

	typedef struct packed {
		logic [4:0] queue_size;
		logic       enabled;
		logic       size_wr;
	} cfg_t;

endpackage

@@ sv/crr_front.sv @@
`timescale 1ns / 1ps
module crr_front (
	input  logic              enabled,
	input  logic [1:0]        mode,
	input  logic [28:0]       raw_id,
	input  logic              extended,
	input  logic              remote,
	input  logic              fd_format,
	input  logic [3:0]        dlc,
	input  logic [63:0]       data,
	output crr_pkg::cmd_t     cmd
);

	logic [3:0] len;

	always_comb begin
		len = (dlc > crr_pkg::MAX_LEN) ? crr_pkg::MAX_LEN : dlc;

		cmd.frame.ext = extended;
		// A standard identifier sits in the top eleven bits of the raw field.
		cmd.frame.id = extended ? raw_id : {18'd0, raw_id[28:18]};
		cmd.frame.len = len;
		for (int b = 0; b < 8; b++) begin
			cmd.frame.data[b*8 +: 8] = (4'(b) < len) ? data[b*8 +: 8] : 8'd0;
		end

		unique case (mode)
			crr_pkg::MODE_PUSH: begin
				cmd.op = (remote || fd_format) ? crr_pkg::OP_NONE : crr_pkg::OP_PUSH;
			end
			crr_pkg::MODE_POP: begin
				cmd.op = crr_pkg::OP_POP;
			end
			crr_pkg::MODE_CLEAR: begin
				cmd.op = crr_pkg::OP_CLEAR;
			end
			default: begin
				cmd.op = crr_pkg::OP_NONE;
			end
		endcase
		if (!enabled) begin
			cmd.op = crr_pkg::OP_NONE;
		end
	end

endmodule

@@ sv/crr_queue.sv @@
`timescale 1ns / 1ps
module crr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  crr_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output crr_pkg::cmd_t out_cmd
);

	crr_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign in_ready = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_cmd = entry_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ sv/crr_back.sv @@
`timescale 1ns / 1ps
module crr_back #(
	parameter int RING_DEPTH = crr_pkg::DEF_RING_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  crr_pkg::cfg_t                  cfg,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  crr_pkg::cmd_t                  cmd,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [crr_pkg::M_TDATA_W-1:0]  res_data,
	output logic [crr_pkg::M_TUSER_W-1:0]  res_user
);

	localparam int IW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
	localparam int SZW_RAW = $clog2(RING_DEPTH + 1);
	localparam int SZW = (SZW_RAW > 5) ? SZW_RAW : 5;

	crr_pkg::frame_t mem [RING_DEPTH];
	crr_pkg::frame_t rd_q;

	logic [IW-1:0]  wr_idx_q;
	logic [IW-1:0]  rd_idx_q;
	logic [31:0]    stored_cnt_q;
	logic [31:0]    drop_cnt_q;
	logic           res_valid_q;
	logic           pop_valid_q;
	logic           push_stored_q;

	logic [SZW-1:0] size;
	logic [IW-1:0]  wr_next;
	logic [IW-1:0]  rd_next;
	logic [SZW-1:0] waiting;
	logic           full;
	logic           empty;
	logic           exec;
	logic           do_store;
	logic           do_pop;
	crr_pkg::frame_t out_frame;

	always_comb begin
		size = SZW'(cfg.queue_size);
		if (size < SZW'(2)) begin
			size = SZW'(2);
		end
		if (size > SZW'(RING_DEPTH)) begin
			size = SZW'(RING_DEPTH);
		end
		wr_next = (SZW'(wr_idx_q) + SZW'(1) == size) ? '0 : wr_idx_q + IW'(1);
		rd_next = (SZW'(rd_idx_q) + SZW'(1) == size) ? '0 : rd_idx_q + IW'(1);
		if (wr_idx_q >= rd_idx_q) begin
			waiting = SZW'(wr_idx_q) - SZW'(rd_idx_q);
		end else begin
			waiting = size - SZW'(rd_idx_q) + SZW'(wr_idx_q);
		end
	end

	assign full = (wr_next == rd_idx_q);
	assign empty = (wr_idx_q == rd_idx_q);
	// One command per cycle, as long as the result register is free or draining.
	assign cmd_ready = !res_valid_q || res_ready;
	assign exec = cmd_valid && cmd_ready;
	assign do_store = exec && (cmd.op == crr_pkg::OP_PUSH) && !full;
	assign do_pop = exec && (cmd.op == crr_pkg::OP_POP) && !empty;

	always_ff @(posedge clk) begin
		if (do_store) begin
			mem[wr_idx_q] <= cmd.frame;
		end
		if (do_pop) begin
			rd_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			stored_cnt_q <= 32'd0;
			drop_cnt_q <= 32'd0;
			res_valid_q <= 1'b0;
			pop_valid_q <= 1'b0;
			push_stored_q <= 1'b0;
		end else begin
			if (exec && !cfg.size_wr) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.size_wr) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
			end else if (exec) begin
				pop_valid_q <= do_pop;
				push_stored_q <= do_store;
				unique case (cmd.op)
					crr_pkg::OP_PUSH: begin
						if (full) begin
							drop_cnt_q <= drop_cnt_q + 32'd1;
						end else begin
							wr_idx_q <= wr_next;
							stored_cnt_q <= stored_cnt_q + 32'd1;
						end
					end
					crr_pkg::OP_POP: begin
						if (!empty) begin
							rd_idx_q <= rd_next;
						end
					end
					crr_pkg::OP_CLEAR: begin
						wr_idx_q <= '0;
						rd_idx_q <= '0;
						stored_cnt_q <= 32'd0;
						drop_cnt_q <= 32'd0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Counters and indices move only on an executed command or a size write, so while
	// a result waits they show the state its command left unless the size is written.
	assign out_frame = pop_valid_q ? rd_q : '0;
	assign res_valid = res_valid_q;
	assign res_user = {push_stored_q, pop_valid_q};
	assign res_data = {2'd0, drop_cnt_q, stored_cnt_q,
		(cfg.enabled ? waiting[3:0] : 4'd0),
		out_frame.data, out_frame.len, out_frame.id, out_frame.ext};

endmodule

@@ sv/can_rx_frame_ring_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       s_tdata, s_tuser (mode)
// m_*       out        m_tvalid / m_tready       m_tdata, m_tuser (pop/push flags)
// cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One beat is taken per cycle while the queue has room; a command waits in a
// two-entry queue and then executes in the back end, whose result register sets
// the rate of one command per cycle unless the output stalls.
// Reset empties the ring, zeroes both counters and sets the size to 16, enabled.
// A stalled output holds the back end; the queue then fills up to its two entries.
module can_rx_frame_ring_top #(
	parameter int RING_DEPTH = crr_pkg::DEF_RING_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata, from bit 0: msg_raw_id[28:0], msg_extended, msg_remote,
	// msg_fd_format, msg_dlc[3:0], msg_data[63:0], zero padding
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [crr_pkg::S_TDATA_W-1:0]       s_tdata,
	// s_tuser, from bit 0: mode[1:0]
	input  logic [crr_pkg::S_TUSER_W-1:0]       s_tuser,
	// m_tdata, from bit 0: out_extended, out_id[28:0], out_length[3:0],
	// out_data[63:0], available[3:0], received_total[31:0],
	// dropped_total[31:0], zero padding
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [crr_pkg::M_TDATA_W-1:0]       m_tdata,
	// m_tuser, from bit 0: pop_valid, push_stored
	output logic [crr_pkg::M_TUSER_W-1:0]       m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [crr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [4:0]    queue_size_q;
	logic          enabled_q;
	crr_pkg::cfg_t cfg;
	crr_pkg::cmd_t front_cmd;
	crr_pkg::cmd_t back_cmd;
	logic          back_valid;
	logic          back_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_size_q <= crr_pkg::QUEUE_SIZE_RST;
			enabled_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				crr_pkg::REG_QUEUE_SIZE: begin
					queue_size_q <= cfg_data[4:0];
				end
				crr_pkg::REG_ENABLED: begin
					enabled_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.queue_size = queue_size_q;
	assign cfg.enabled = enabled_q;
	assign cfg.size_wr = cfg_valid && (cfg_index == crr_pkg::REG_QUEUE_SIZE);

	crr_front u_front (
		.enabled   (enabled_q),
		.mode      (s_tuser[1:0]),
		.raw_id    (s_tdata[28:0]),
		.extended  (s_tdata[29]),
		.remote    (s_tdata[30]),
		.fd_format (s_tdata[31]),
		.dlc       (s_tdata[35:32]),
		.data      (s_tdata[99:36]),
		.cmd       (front_cmd)
	);

	crr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (front_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_cmd   (back_cmd)
	);

	crr_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata),
		.res_user  (m_tuser)
	);

endmodule

@@ sv/crr_checker.sv @@
`timescale 1ns / 1ps
`include "can_rx_frame_ring_top_assert.svh"
module crr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [crr_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [crr_pkg::M_TUSER_W-1:0] m_tuser
);

	`CRR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
	`CRR_ASSERT_IMPLY(a_one_flag, clk, arst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]), "pop and push flags both set")
	`CRR_ASSERT_IMPLY(a_no_frame, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[97:0] == 98'd0, "frame fields not zero without a pop")
	`CRR_ASSERT_IMPLY(a_len_max, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[33:30] <= 4'd8, "popped length above eight")

endmodule

bind can_rx_frame_ring_top crr_checker u_crr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
